// ===== design/bps_pkg.sv =====
// shared types, constants and tone tables of the buzzer pattern sequencer
package bps_pkg;

    // sizing
    localparam int MAX_SYSTEMS = 8;
    localparam int TIME_BITS   = 32;
    localparam int NOW_W       = 32;
    localparam int FREQ_W      = 12;
    localparam int DUR_W       = 12;
    localparam int CNT_W       = 4;
    localparam int SYS_W       = 3;
    localparam int MASK_W      = 8;
    localparam int PAT_W       = 3;
    localparam int OP_W        = 2;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 16;

    typedef logic [TIME_BITS-1:0] tstamp_t;
    typedef logic [DUR_W-1:0]     dur_t;
    typedef logic [FREQ_W-1:0]    freq_t;

    // item kinds
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_PATTERN  = 2'd1,
        OP_CHIRP    = 2'd2,
        OP_SELFTEST = 2'd3
    } op_t;

    // pattern codes, anything above armed is silent
    localparam logic [PAT_W-1:0] PAT_SILENT = 3'd0;
    localparam logic [PAT_W-1:0] PAT_FAULT  = 3'd1;
    localparam logic [PAT_W-1:0] PAT_PREARM = 3'd2;
    localparam logic [PAT_W-1:0] PAT_ARMED  = 3'd3;

    // chirp
    localparam freq_t CHIRP_FREQ = 12'd2700;
    localparam dur_t  CHIRP_ON   = 12'd80;
    localparam dur_t  CHIRP_NEXT = 12'd120;

    // self-test beep code
    localparam freq_t ST_COUNT_FREQ = 12'd1800;
    localparam dur_t  ST_COUNT_ON   = 12'd80;
    localparam dur_t  ST_COUNT_GAP  = 12'd120;
    localparam dur_t  ST_PAUSE_GAP  = 12'd350;
    localparam freq_t ST_OK_FREQ    = 12'd1100;
    localparam dur_t  ST_OK_ON      = 12'd70;
    localparam dur_t  ST_OK_GAP     = 12'd90;
    localparam freq_t ST_FAULT_FREQ = 12'd3200;
    localparam dur_t  ST_FAULT_ON   = 12'd500;
    localparam dur_t  ST_NEXT_GAP   = 12'd600;

    // one accepted input item
    typedef struct packed {
        op_t               op;
        logic [NOW_W-1:0]  now_ms;
        logic [PAT_W-1:0]  pattern;
        logic [MASK_W-1:0] system_ok_mask;
        logic [CNT_W-1:0]  system_count;
    } item_t;

    // one result item, buzzer_on in the lowest bit
    typedef struct packed {
        logic  selftest_busy;
        logic  beep_stopped;
        logic  beep_started;
        freq_t tone_freq_hz;
        logic  buzzer_on;
    } result_t;

    // period of a periodic pattern, zero for silent
    function automatic dur_t pat_period(input logic [PAT_W-1:0] p);
        dur_t r;
        case (p)
            PAT_FAULT:  r = 12'd250;
            PAT_PREARM: r = 12'd2000;
            PAT_ARMED:  r = 12'd3000;
            default:    r = '0;
        endcase
        return r;
    endfunction

    // on time of a periodic pattern
    function automatic dur_t pat_on(input logic [PAT_W-1:0] p);
        dur_t r;
        case (p)
            PAT_FAULT:  r = 12'd120;
            PAT_PREARM: r = 12'd80;
            PAT_ARMED:  r = 12'd60;
            default:    r = '0;
        endcase
        return r;
    endfunction

    // tone of a periodic pattern
    function automatic freq_t pat_freq(input logic [PAT_W-1:0] p);
        freq_t r;
        case (p)
            PAT_FAULT:  r = 12'd2000;
            PAT_PREARM: r = 12'd1500;
            PAT_ARMED:  r = 12'd2500;
            default:    r = '0;
        endcase
        return r;
    endfunction

    // true when now is at or after when, by the signed difference
    function automatic logic reached(input tstamp_t now, input tstamp_t when);
        tstamp_t d;
        d = now - when;
        return ~d[TIME_BITS-1];
    endfunction

endpackage

// ===== design/bps_core.sv =====
// buzzer scheduler state and the single-pass update for one item
module bps_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  bps_pkg::item_t   item,
    output bps_pkg::result_t result
);

    logic [bps_pkg::PAT_W-1:0]  active_pattern_reg, active_pattern_next;
    bps_pkg::tstamp_t           next_beep_time_reg, next_beep_time_next;
    bps_pkg::tstamp_t           beep_off_time_reg, beep_off_time_next;
    logic                       beep_active_reg, beep_active_next;
    bps_pkg::freq_t             tone_freq_reg, tone_freq_next;
    logic                       test_active_reg, test_active_next;
    logic [bps_pkg::MASK_W-1:0] test_ok_bits_reg, test_ok_bits_next;
    logic [bps_pkg::CNT_W-1:0]  test_total_reg, test_total_next;
    logic [bps_pkg::CNT_W-1:0]  test_index_reg, test_index_next;
    logic [bps_pkg::CNT_W-1:0]  test_step_reg, test_step_next;
    bps_pkg::tstamp_t           test_next_time_reg, test_next_time_next;
    logic                       started, stopped;

    // next state and result for the item in the input register
    always_comb
    begin
        bps_pkg::tstamp_t          now_t;
        logic                      off_now;
        logic [bps_pkg::SYS_W-1:0] sys;
        logic [bps_pkg::PAT_W-1:0] p;
        bps_pkg::freq_t            freq;
        bps_pkg::dur_t             on_ms;
        bps_pkg::dur_t             gap;
        logic                      last;
        logic [bps_pkg::CNT_W-1:0] cnt;

        now_t   = item.now_ms[bps_pkg::TIME_BITS-1:0];
        off_now = beep_active_reg;
        sys     = test_index_reg[bps_pkg::SYS_W-1:0];
        p       = (active_pattern_reg <= bps_pkg::PAT_ARMED) ? active_pattern_reg
                                                             : bps_pkg::PAT_SILENT;
        freq    = bps_pkg::ST_COUNT_FREQ;
        on_ms   = bps_pkg::ST_COUNT_ON;
        gap     = bps_pkg::ST_COUNT_GAP;
        last    = 1'b0;
        cnt     = item.system_count;

        active_pattern_next = active_pattern_reg;
        next_beep_time_next = next_beep_time_reg;
        beep_off_time_next  = beep_off_time_reg;
        beep_active_next    = beep_active_reg;
        tone_freq_next      = tone_freq_reg;
        test_active_next    = test_active_reg;
        test_ok_bits_next   = test_ok_bits_reg;
        test_total_next     = test_total_reg;
        test_index_next     = test_index_reg;
        test_step_next      = test_step_reg;
        test_next_time_next = test_next_time_reg;
        started             = 1'b0;
        stopped             = 1'b0;

        // beep code step for the current system
        if (test_step_reg <= {1'b0, sys})
        begin
            freq  = bps_pkg::ST_COUNT_FREQ;
            on_ms = bps_pkg::ST_COUNT_ON;
            gap   = (test_step_reg == {1'b0, sys}) ? bps_pkg::ST_PAUSE_GAP
                                                   : bps_pkg::ST_COUNT_GAP;
        end
        else if (test_ok_bits_reg[sys])
        begin
            freq  = bps_pkg::ST_OK_FREQ;
            on_ms = bps_pkg::ST_OK_ON;
            if (test_step_reg == ({1'b0, sys} + 4'd1))
            begin
                gap = bps_pkg::ST_OK_GAP;
            end
            else
            begin
                gap  = bps_pkg::ST_NEXT_GAP;
                last = 1'b1;
            end
        end
        else
        begin
            freq  = bps_pkg::ST_FAULT_FREQ;
            on_ms = bps_pkg::ST_FAULT_ON;
            gap   = bps_pkg::ST_NEXT_GAP;
            last  = 1'b1;
        end

        case (item.op)
            bps_pkg::OP_TICK:
            begin
                // close an expired beep
                if (beep_active_reg && bps_pkg::reached(now_t, beep_off_time_reg))
                begin
                    beep_active_next = 1'b0;
                    off_now          = 1'b0;
                    stopped          = 1'b1;
                end
                if (test_active_reg)
                begin
                    if (!off_now && bps_pkg::reached(now_t, test_next_time_reg))
                    begin
                        if (test_index_reg < test_total_reg)
                        begin
                            if (last)
                            begin
                                test_index_next = test_index_reg + 4'd1;
                                test_step_next  = '0;
                            end
                            else
                            begin
                                test_step_next = test_step_reg + 4'd1;
                            end
                            tone_freq_next      = freq;
                            beep_off_time_next  = now_t + bps_pkg::TIME_BITS'(on_ms);
                            beep_active_next    = 1'b1;
                            started             = 1'b1;
                            test_next_time_next = now_t + bps_pkg::TIME_BITS'(on_ms + gap);
                        end
                        else
                        begin
                            test_active_next    = 1'b0;
                            next_beep_time_next = '0;
                        end
                    end
                end
                else if (bps_pkg::pat_period(p) != '0)
                begin
                    // retrigger the periodic pattern
                    if (next_beep_time_reg == '0
                        || bps_pkg::reached(now_t, next_beep_time_reg))
                    begin
                        tone_freq_next      = bps_pkg::pat_freq(p);
                        beep_off_time_next  = now_t + bps_pkg::TIME_BITS'(bps_pkg::pat_on(p));
                        beep_active_next    = 1'b1;
                        started             = 1'b1;
                        next_beep_time_next = now_t
                                              + bps_pkg::TIME_BITS'(bps_pkg::pat_period(p));
                    end
                end
            end
            bps_pkg::OP_PATTERN:
            begin
                if (!(item.pattern == active_pattern_reg && !test_active_reg))
                begin
                    active_pattern_next = item.pattern;
                    test_active_next    = 1'b0;
                    next_beep_time_next = '0;
                end
            end
            bps_pkg::OP_CHIRP:
            begin
                tone_freq_next      = bps_pkg::CHIRP_FREQ;
                beep_off_time_next  = now_t + bps_pkg::TIME_BITS'(bps_pkg::CHIRP_ON);
                beep_active_next    = 1'b1;
                started             = 1'b1;
                next_beep_time_next = now_t + bps_pkg::TIME_BITS'(bps_pkg::CHIRP_NEXT);
            end
            bps_pkg::OP_SELFTEST:
            begin
                if (cnt > bps_pkg::CNT_W'(bps_pkg::MAX_SYSTEMS))
                    cnt = bps_pkg::CNT_W'(bps_pkg::MAX_SYSTEMS);
                test_ok_bits_next   = item.system_ok_mask;
                test_total_next     = cnt;
                test_index_next     = '0;
                test_step_next      = '0;
                test_next_time_next = '0;
                test_active_next    = (cnt != '0);
            end
            default:
            begin
                active_pattern_next = active_pattern_reg;
            end
        endcase
    end

    // result after the update
    assign result.buzzer_on     = beep_active_next;
    assign result.tone_freq_hz  = tone_freq_next;
    assign result.beep_started  = started;
    assign result.beep_stopped  = stopped;
    assign result.selftest_busy = test_active_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_pattern_reg <= bps_pkg::PAT_SILENT;
            next_beep_time_reg <= '0;
            beep_off_time_reg  <= '0;
            beep_active_reg    <= 1'b0;
            tone_freq_reg      <= '0;
            test_active_reg    <= 1'b0;
            test_ok_bits_reg   <= '0;
            test_total_reg     <= '0;
            test_index_reg     <= '0;
            test_step_reg      <= '0;
            test_next_time_reg <= '0;
        end
        else if (step)
        begin
            active_pattern_reg <= active_pattern_next;
            next_beep_time_reg <= next_beep_time_next;
            beep_off_time_reg  <= beep_off_time_next;
            beep_active_reg    <= beep_active_next;
            tone_freq_reg      <= tone_freq_next;
            test_active_reg    <= test_active_next;
            test_ok_bits_reg   <= test_ok_bits_next;
            test_total_reg     <= test_total_next;
            test_index_reg     <= test_index_next;
            test_step_reg      <= test_step_next;
            test_next_time_reg <= test_next_time_next;
        end
    end

    // a running self-test always has systems to report
    a_test_has_systems: assert property (@(posedge clk) disable iff (!rst_n)
        test_active_reg |-> (test_total_reg != '0))
        else $error("self-test active with zero systems");

    // the system count never exceeds the supported number
    a_total_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        test_total_reg <= bps_pkg::CNT_W'(bps_pkg::MAX_SYSTEMS))
        else $error("self-test system total above limit");

    // only a sounding beep can be switched off
    a_stop_needs_beep: assert property (@(posedge clk) disable iff (!rst_n)
        (step && stopped) |-> beep_active_reg)
        else $error("beep stopped while none was sounding");

    // a started beep is sounding afterwards
    a_start_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        (step && started) |=> beep_active_reg)
        else $error("beep started but buzzer not active");

endmodule

// ===== design/buzzer_pattern_sequencer.sv =====
// Buzzer pattern sequencer: takes one item per clock cycle, sustained unless stalled. An
// accepted item sits in an input register while the scheduler state is updated
// from it, and its result is loaded into the output register that drives m_tvalid.
// A result held in the output register by m_tready low stalls the input
// register behind it, and s_tready then falls in that same cycle; nothing
// else stalls the block.
// All timing is relative to the now_ms stamps carried by the items, compared
// by signed 32-bit difference, so the block needs no timer of its own.
module buzzer_pattern_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_ms[31:0], pattern[34:32], system_ok_mask[42:35], system_count[46:43], zero pad
    input  logic [bps_pkg::S_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [bps_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // buzzer_on[0], tone_freq_hz[12:1], beep_started[13], beep_stopped[14],
    // selftest_busy[15]
    output logic [bps_pkg::M_DATA_W-1:0]  m_tdata
);

    logic             in_vld_reg;
    bps_pkg::item_t   in_item_reg;
    bps_pkg::item_t   in_item_next;
    logic             out_vld_reg;
    bps_pkg::result_t out_res_reg;
    bps_pkg::result_t core_res;
    logic             advance;
    logic             take_in;

    // handshake between the two stages
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    // unpack the incoming item
    assign in_item_next.op             = bps_pkg::op_t'(s_tuser);
    assign in_item_next.now_ms         = s_tdata[31:0];
    assign in_item_next.pattern        = s_tdata[34:32];
    assign in_item_next.system_ok_mask = s_tdata[42:35];
    assign in_item_next.system_count   = s_tdata[46:43];

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= in_item_next;
        end
    end

    // scheduler
    bps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg;

endmodule

// ===== tb/buzzer_pattern_sequencer_tb.sv =====
// self-checking testbench of the buzzer pattern sequencer, with its own tone scheduler model
module buzzer_pattern_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 1200;
    localparam int  TAIL_ITEMS   = 100;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  CYCLE_LIMIT  = 400000;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bps_pkg::S_DATA_W-1:0]  s_tdata  = '0;
    logic [bps_pkg::OP_W-1:0]      s_tuser  = bps_pkg::OP_TICK;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bps_pkg::M_DATA_W-1:0]  m_tdata;

    buzzer_pattern_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // stimulus and expected results
    bps_pkg::item_t   stim_items[$];
    bps_pkg::result_t tone_results_due[$];
    bps_pkg::item_t   on_bus;
    int               n_total;
    int               n_sent = 0;
    int               errors = 0;
    int               cycles = 0;

    // idling control
    int      src_gap = 0;
    int      snk_gap = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    bit      quiet_tail = 1'b0;

    // scheduler model state
    logic [bps_pkg::PAT_W-1:0]  sched_pattern;
    bps_pkg::tstamp_t           pattern_due;
    bps_pkg::tstamp_t           tone_end;
    bit                         tone_live;
    bps_pkg::freq_t             tone_hz;
    bit                         code_running;
    logic [bps_pkg::MASK_W-1:0] code_pass_bits;
    logic [bps_pkg::CNT_W-1:0]  code_total;
    logic [bps_pkg::CNT_W-1:0]  code_sys;
    logic [bps_pkg::CNT_W-1:0]  code_step;
    bps_pkg::tstamp_t           code_due;

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // reset, held low at the start and then released
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void clear_model();
        sched_pattern  = bps_pkg::PAT_SILENT;
        pattern_due    = '0;
        tone_end       = '0;
        tone_live      = 1'b0;
        tone_hz        = '0;
        code_running   = 1'b0;
        code_pass_bits = '0;
        code_total     = '0;
        code_sys       = '0;
        code_step      = '0;
        code_due       = '0;
    endfunction

    // signed difference compare of two wrapping time stamps
    function automatic bit is_due(input bps_pkg::tstamp_t now, input bps_pkg::tstamp_t when);
        return $signed(now - when) >= 0;
    endfunction

    function automatic void start_tone(input bps_pkg::freq_t freq, input bps_pkg::dur_t on_ms,
                                       input bps_pkg::tstamp_t now);
        tone_hz   = freq;
        tone_end  = now + on_ms;
        tone_live = 1'b1;
    endfunction

    // one tick of the scheduler
    function automatic void tick_model(input bps_pkg::tstamp_t now, output bit started,
                                       output bit stopped);
        int             sys;
        int             step;
        bps_pkg::freq_t freq;
        bps_pkg::dur_t  on_ms;
        bps_pkg::dur_t  gap;
        bps_pkg::dur_t  period;
        bit             last;
        started = 1'b0;
        stopped = 1'b0;
        if (tone_live && is_due(now, tone_end))
        begin
            tone_live = 1'b0;
            stopped   = 1'b1;
        end
        if (code_running)
        begin
            if (!tone_live && is_due(now, code_due))
            begin
                if (code_sys < code_total)
                begin
                    sys  = int'(code_sys[2:0]);
                    step = int'(code_step);
                    last = 1'b0;
                    // count beeps, then the verdict of this system
                    if (step <= sys)
                    begin
                        freq  = bps_pkg::ST_COUNT_FREQ;
                        on_ms = bps_pkg::ST_COUNT_ON;
                        gap   = (step == sys) ? bps_pkg::ST_PAUSE_GAP : bps_pkg::ST_COUNT_GAP;
                    end
                    else if (code_pass_bits[sys])
                    begin
                        freq  = bps_pkg::ST_OK_FREQ;
                        on_ms = bps_pkg::ST_OK_ON;
                        if (step == sys + 1)
                            gap = bps_pkg::ST_OK_GAP;
                        else
                        begin
                            gap  = bps_pkg::ST_NEXT_GAP;
                            last = 1'b1;
                        end
                    end
                    else
                    begin
                        freq  = bps_pkg::ST_FAULT_FREQ;
                        on_ms = bps_pkg::ST_FAULT_ON;
                        gap   = bps_pkg::ST_NEXT_GAP;
                        last  = 1'b1;
                    end
                    if (last)
                    begin
                        code_sys  = code_sys + 1'b1;
                        code_step = '0;
                    end
                    else
                        code_step = code_step + 1'b1;
                    start_tone(freq, on_ms, now);
                    started  = 1'b1;
                    code_due = now + on_ms + gap;
                end
                else
                begin
                    code_running = 1'b0;
                    pattern_due  = '0;
                end
            end
        end
        else
        begin
            // periodic pattern, codes above armed are silent
            case (sched_pattern)
                bps_pkg::PAT_FAULT:
                begin
                    period = 12'd250;
                    on_ms  = 12'd120;
                    freq   = 12'd2000;
                end
                bps_pkg::PAT_PREARM:
                begin
                    period = 12'd2000;
                    on_ms  = 12'd80;
                    freq   = 12'd1500;
                end
                bps_pkg::PAT_ARMED:
                begin
                    period = 12'd3000;
                    on_ms  = 12'd60;
                    freq   = 12'd2500;
                end
                default:
                begin
                    period = '0;
                    on_ms  = '0;
                    freq   = '0;
                end
            endcase
            if (period != 0 && (pattern_due == 0 || is_due(now, pattern_due)))
            begin
                start_tone(freq, on_ms, now);
                started     = 1'b1;
                pattern_due = now + period;
            end
        end
    endfunction

    // expected result of one accepted item
    function automatic bps_pkg::result_t predict_buzzer(input bps_pkg::item_t it);
        bps_pkg::result_t r;
        bit               started;
        bit               stopped;
        started = 1'b0;
        stopped = 1'b0;
        case (it.op)
            bps_pkg::OP_TICK:
                tick_model(it.now_ms, started, stopped);
            bps_pkg::OP_PATTERN:
            begin
                if (!(it.pattern == sched_pattern && !code_running))
                begin
                    sched_pattern = it.pattern;
                    code_running  = 1'b0;
                    pattern_due   = '0;
                end
            end
            bps_pkg::OP_CHIRP:
            begin
                start_tone(bps_pkg::CHIRP_FREQ, bps_pkg::CHIRP_ON, it.now_ms);
                started     = 1'b1;
                pattern_due = it.now_ms + bps_pkg::CHIRP_NEXT;
            end
            default:
            begin
                code_pass_bits = it.system_ok_mask;
                code_total     = (it.system_count > bps_pkg::CNT_W'(bps_pkg::MAX_SYSTEMS))
                                 ? bps_pkg::CNT_W'(bps_pkg::MAX_SYSTEMS) : it.system_count;
                code_sys       = '0;
                code_step      = '0;
                code_due       = '0;
                code_running   = (code_total != 0);
            end
        endcase
        r.buzzer_on     = tone_live;
        r.tone_freq_hz  = tone_hz;
        r.beep_started  = started;
        r.beep_stopped  = stopped;
        r.selftest_busy = code_running;
        return r;
    endfunction

    function automatic void add_item(input bps_pkg::op_t op, input bps_pkg::tstamp_t now,
                                     input logic [bps_pkg::PAT_W-1:0] pattern,
                                     input logic [bps_pkg::MASK_W-1:0] mask,
                                     input logic [bps_pkg::CNT_W-1:0] count);
        bps_pkg::item_t it;
        it.op             = op;
        it.now_ms         = now;
        it.pattern        = pattern;
        it.system_ok_mask = mask;
        it.system_count   = count;
        stim_items.push_back(it);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // driver: presents queued items, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= bps_pkg::OP_TICK;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tone_results_due.push_back(predict_buzzer(on_bus));
                n_sent++;
                // change the idling mix now and then, sometimes to none at all
                if (n_sent % 64 == 0)
                begin
                    src_idle_pct  <= 15 * $urandom_range(3);
                    snk_stall_pct <= 15 * $urandom_range(3);
                end
            end
            quiet_tail <= (stim_items.size() < TAIL_ITEMS);
            if (s_tvalid && !s_tready)
            begin
                // hold the item until taken
            end
            else if (src_gap != 0)
            begin
                src_gap  = src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (stim_items.size() != 0)
            begin
                if (!quiet_tail && $urandom_range(99) < src_idle_pct)
                begin
                    src_gap  = $urandom_range(11);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus   = stim_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, on_bus.system_count, on_bus.system_ok_mask,
                                 on_bus.pattern, on_bus.now_ms};
                    s_tuser  <= on_bus.op;
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor: compares each result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : monitor
        bps_pkg::result_t got;
        bps_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = bps_pkg::result_t'(m_tdata);
                if (tone_results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = tone_results_due.pop_front();
                    check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
                    check_field("tone_freq_hz", want.tone_freq_hz, got.tone_freq_hz);
                    check_field("beep_started", want.beep_started, got.beep_started);
                    check_field("beep_stopped", want.beep_stopped, got.beep_stopped);
                    check_field("selftest_busy", want.selftest_busy, got.selftest_busy);
                end
            end
            if (snk_gap != 0)
            begin
                snk_gap  = snk_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(99) < snk_stall_pct)
            begin
                snk_gap  = $urandom_range(11);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // run time limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        bps_pkg::item_t   it;
        bps_pkg::tstamp_t t;
        int               roll;
        bit               noise;
        clear_model();

        // directed: pattern start, repeat and change, chirp, wrap and self-test cases
        add_item(bps_pkg::OP_TICK,     32'd0,         bps_pkg::PAT_SILENT, 8'h00, 4'd0);
        add_item(bps_pkg::OP_PATTERN,  32'd0,         bps_pkg::PAT_FAULT,  8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd5,         3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_PATTERN,  32'd10,        bps_pkg::PAT_FAULT,  8'hFF, 4'd15);
        add_item(bps_pkg::OP_TICK,     32'd130,       3'd7,                8'hFF, 4'd15);
        add_item(bps_pkg::OP_TICK,     32'd255,       3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_PATTERN,  32'd260,       bps_pkg::PAT_PREARM, 8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd261,       3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_CHIRP,    32'd300,       3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd400,       3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_SELFTEST, 32'd500,       3'd0,                8'hFF, 4'd0);
        add_item(bps_pkg::OP_SELFTEST, 32'h8000_0000, 3'd0,                8'hFF, 4'd15);
        // upper half of the time range waits for the wrap
        add_item(bps_pkg::OP_TICK,     32'hFFFF_FFF0, 3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd4,         3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_CHIRP,    32'd10,        3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd440,       3'd0,                8'h00, 4'd0);
        // same pattern again cancels the running self-test
        add_item(bps_pkg::OP_PATTERN,  32'd450,       bps_pkg::PAT_PREARM, 8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd600,       3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_SELFTEST, 32'd700,       3'd0,                8'h00, 4'd9);
        add_item(bps_pkg::OP_TICK,     32'd700,       3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_PATTERN,  32'd900,       3'd7,                8'h00, 4'd0);
        add_item(bps_pkg::OP_PATTERN,  32'd1000,      bps_pkg::PAT_ARMED,  8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd1001,      3'd0,                8'h00, 4'd0);
        // one failing system, then the pattern resumes
        add_item(bps_pkg::OP_SELFTEST, 32'd1050,      3'd0,                8'h00, 4'd1);
        add_item(bps_pkg::OP_TICK,     32'd1100,      3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd1530,      3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd2630,      3'd0,                8'h00, 4'd0);
        add_item(bps_pkg::OP_TICK,     32'd2631,      3'd0,                8'h00, 4'd0);

        // random: mostly ticks on a rising time base, with occasional commands and noise
        t = $urandom;
        repeat (RANDOM_ITEMS)
        begin
            roll              = $urandom_range(999);
            noise             = 1'b0;
            it.op             = bps_pkg::OP_TICK;
            it.pattern        = bps_pkg::PAT_W'($urandom);
            it.system_ok_mask = bps_pkg::MASK_W'($urandom);
            it.system_count   = bps_pkg::CNT_W'($urandom);
            if (roll < 15)
                it.op = bps_pkg::OP_PATTERN;
            else if (roll < 35)
                it.op = bps_pkg::OP_CHIRP;
            else if (roll < 50)
            begin
                it.op = bps_pkg::OP_SELFTEST;
                if ($urandom_range(7) != 0)
                    it.system_count = bps_pkg::CNT_W'($urandom_range(3, 1));
            end
            else if (roll < 80)
            begin
                it.op = bps_pkg::op_t'($urandom_range(3));
                noise = 1'b1;
            end
            if ($urandom_range(19) == 0)
                t = t + $urandom_range(4000, 200);
            else
                t = t + $urandom_range(60, 1);
            it.now_ms = noise ? bps_pkg::tstamp_t'($urandom) : t;
            stim_items.push_back(it);
        end
        n_total = stim_items.size();

        // wait for every item to be taken and every result to come back
        @(posedge rst_n);
        while (n_sent != n_total || tone_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && tone_results_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bps_pkg.sv
design/bps_core.sv
design/buzzer_pattern_sequencer.sv
tb/buzzer_pattern_sequencer_tb.sv
